// ===== hdl/dec_pkg.sv =====
// Shared types and constants for the debounced edge counter.
package dec_pkg;

   localparam int CHANNELS = 4;

   localparam int CHAN_W  = 2;
   localparam int COUNT_W = 16;
   localparam int STAMP_W = 32;
   localparam int WIN_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_ENABLE_MASK = 3'd0;
   localparam csr_index_type CSR_DEBOUNCE_CH0 = 3'd1;
   localparam csr_index_type CSR_DEBOUNCE_CH1 = 3'd2;
   localparam csr_index_type CSR_DEBOUNCE_CH2 = 3'd3;
   localparam csr_index_type CSR_DEBOUNCE_CH3 = 3'd4;

   typedef struct packed {
      logic [CHANNELS-1:0]            enable;
      logic [CHANNELS-1:0][WIN_W-1:0] window;
   } cfg_type;

   typedef struct packed {
      logic               level;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [CHAN_W-1:0] addr;
      entry_type         data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [CHAN_W-1:0] addr;
   } mem_rd_type;

endpackage

// ===== hdl/dec_if.sv =====
// Handshake interfaces for request, response and register write channels.
interface dec_req_if;
   import dec_pkg::*;
   logic               valid;
   logic               ready;
   logic [CHAN_W-1:0]  channel;
   logic               pin_level;
   logic [STAMP_W-1:0] now_ms;
   modport source (output valid, output channel, output pin_level, output now_ms, input ready);
   modport sink   (input valid, input channel, input pin_level, input now_ms, output ready);
endinterface

interface dec_rsp_if;
   import dec_pkg::*;
   logic               valid;
   logic               ready;
   logic [CHAN_W-1:0]  out_channel;
   logic               out_level;
   logic [COUNT_W-1:0] edge_count;
   logic               accepted;
   logic               rising_counted;
   modport source (output valid, output out_channel, output out_level, output edge_count,
                   output accepted, output rising_counted, input ready);
   modport sink   (input valid, input out_channel, input out_level, input edge_count,
                   input accepted, input rising_counted, output ready);
endinterface

interface dec_csr_if;
   import dec_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/debounced_edge_counter_core.sv =====
// Top level of the debounced edge counter: request pipeline, update logic and response register.
// Takes one request per clock unless the response side stalls stage 1, and returns one response
// per request through the stage 1 and response registers. The channel state (level, rise count,
// last accepted timestamp) sits in a four-entry memory with a registered read; the read is
// issued as the request is taken, the update is computed in the next cycle and written back,
// and a write-first bypass on the read port lets the next request on the same channel follow
// at once. A response waiting in the output register does not stop the pipeline stage behind
// it from filling. After reset every channel reads as level 0, count 0, timestamp 0 with no
// clearing pass. Register writes are taken every cycle and are meant to happen while idle.
module debounced_edge_counter_core (
   input  logic       clock,
   input  logic       reset,
   dec_req_if.sink    req_bus,
   dec_rsp_if.source  rsp_bus,
   dec_csr_if.sink    csr_bus
);
   import dec_pkg::*;

   cfg_type    cfg;
   mem_rd_type rd;
   mem_wr_type wr;
   entry_type  cur_entry;
   entry_type  new_entry;

   logic               s1_valid_ff, s1_valid_in;
   logic [CHAN_W-1:0]  s1_channel_ff;
   logic               s1_level_ff;
   logic [STAMP_W-1:0] s1_now_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]  rsp_channel_ff;
   logic               rsp_level_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_accepted_ff;
   logic               rsp_rise_ff;

   logic               req_ready;
   logic               req_fire;
   logic               s1_adv;
   logic               ch_enabled;
   logic [STAMP_W-1:0] elapsed;
   logic               window_pass;
   logic               accept;
   logic               rise;

   dec_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   dec_state_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd      (rd),
      .wr      (wr),
      .rd_data (cur_entry)
   );

   // Stage 1 advances whenever the response register is empty or being drained.
   assign s1_adv    = !rsp_valid_ff || rsp_bus.ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   assign rd.en   = req_fire;
   assign rd.addr = req_bus.channel;

   always_comb begin
      ch_enabled  = (int'(s1_channel_ff) < CHANNELS) && cfg.enable[s1_channel_ff];
      elapsed     = s1_now_ff - cur_entry.stamp;
      window_pass = elapsed >= {{(STAMP_W-WIN_W){1'b0}}, cfg.window[s1_channel_ff]};
      accept      = ch_enabled && window_pass;
      rise        = accept && s1_level_ff && !cur_entry.level;

      new_entry = cur_entry;
      if (accept) begin
         new_entry.stamp = s1_now_ff;
         new_entry.level = s1_level_ff;
         if (rise) begin
            new_entry.count = cur_entry.count + COUNT_W'(1);
         end
      end
   end

   assign wr.en   = s1_valid_ff && s1_adv && accept;
   assign wr.addr = s1_channel_ff;
   assign wr.data = new_entry;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_channel_ff <= req_bus.channel;
         s1_level_ff   <= req_bus.pin_level;
         s1_now_ff     <= req_bus.now_ms;
      end
   end

   // Disabled channels report zeros apart from the channel; dropped requests report the stored state.
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_adv) begin
         rsp_channel_ff  <= s1_channel_ff;
         rsp_level_ff    <= ch_enabled && new_entry.level;
         rsp_count_ff    <= ch_enabled ? new_entry.count : '0;
         rsp_accepted_ff <= accept;
         rsp_rise_ff     <= rise;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.out_channel    = rsp_channel_ff;
   assign rsp_bus.out_level      = rsp_level_ff;
   assign rsp_bus.edge_count     = rsp_count_ff;
   assign rsp_bus.accepted       = rsp_accepted_ff;
   assign rsp_bus.rising_counted = rsp_rise_ff;

   a_rise_implies_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rise_ff |-> rsp_accepted_ff && rsp_level_ff)
      else $error("rise reported without an accepted high level");

   a_write_on_advance: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> s1_valid_ff && s1_adv)
      else $error("state written without an advancing request");

   a_bypass_same_channel: assert property (@(posedge clock) disable iff (reset)
      wr.en && req_fire && req_bus.channel == wr.addr |=> cur_entry == $past(wr.data))
      else $error("back-to-back request missed the preceding update");

   a_stall_blocks_request: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !req_ready)
      else $error("request taken while the update stage is stalled");

endmodule

// ===== hdl/dec_csr.sv =====
// Configuration registers: channel enable mask and per-channel debounce windows.
module dec_csr (
   input  logic             clock,
   input  logic             reset,
   dec_csr_if.sink          csr_bus,
   output dec_pkg::cfg_type cfg
);
   import dec_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_fire;

   assign csr_bus.ready = 1'b1;
   assign wr_fire       = csr_bus.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         unique case (csr_bus.index)
            CSR_ENABLE_MASK:  cfg_in.enable    = csr_bus.data[CHANNELS-1:0];
            CSR_DEBOUNCE_CH0: cfg_in.window[0] = csr_bus.data[WIN_W-1:0];
            CSR_DEBOUNCE_CH1: cfg_in.window[1] = csr_bus.data[WIN_W-1:0];
            CSR_DEBOUNCE_CH2: cfg_in.window[2] = csr_bus.data[WIN_W-1:0];
            CSR_DEBOUNCE_CH3: cfg_in.window[3] = csr_bus.data[WIN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/dec_state_mem.sv =====
// Per-channel state memory with registered read, write-first bypass and reset valid bits.
module dec_state_mem (
   input  logic               clock,
   input  logic               reset,
   input  dec_pkg::mem_rd_type rd,
   input  dec_pkg::mem_wr_type wr,
   output dec_pkg::entry_type  rd_data
);
   import dec_pkg::*;

   entry_type           state_mem[CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   logic [CHANNELS-1:0] valid_in;
   entry_type           rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         state_mem[wr.addr] <= wr.data;
      end
   end

   // Take the write of the same edge so a back-to-back request sees it.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         if (wr.en && wr.addr == rd.addr) begin
            rd_data_ff <= wr.data;
         end else if (valid_ff[rd.addr]) begin
            rd_data_ff <= state_mem[rd.addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/debounced_edge_counter_core_tb.sv =====
// Self-checking testbench for the debounced edge counter core.
module debounced_edge_counter_core_tb;
   import dec_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 150;

   typedef struct packed {
      logic [CHAN_W-1:0]  channel;
      logic               level;
      logic [COUNT_W-1:0] count;
      logic               accepted;
      logic               rose;
   } event_result_type;

   // Predicts one response per request from its own copy of the channel state.
   class edge_count_scoreboard;
      logic [CHANNELS-1:0] enable_mask;
      logic [WIN_W-1:0]    window [CHANNELS];
      logic                level [CHANNELS];
      logic [COUNT_W-1:0]  rises [CHANNELS];
      logic [STAMP_W-1:0]  stamp [CHANNELS];
      event_result_type    expected_q [$];
      int                  errors;

      function new();
         enable_mask = '0;
         errors = 0;
         for (int c = 0; c < CHANNELS; c++) begin
            window[c] = '0;
            level[c]  = 1'b0;
            rises[c]  = '0;
            stamp[c]  = '0;
         end
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] wdata);
         case (idx) inside
            CSR_ENABLE_MASK: enable_mask = wdata[CHANNELS-1:0];
            CSR_DEBOUNCE_CH0, CSR_DEBOUNCE_CH1, CSR_DEBOUNCE_CH2, CSR_DEBOUNCE_CH3: begin
               window[CHAN_W'(idx - CSR_DEBOUNCE_CH0)] = wdata[WIN_W-1:0];
            end
            default: ;
         endcase
      endfunction

      function void note_request(logic [CHAN_W-1:0] ch, logic lvl, logic [STAMP_W-1:0] now);
         event_result_type   r;
         logic [STAMP_W-1:0] gap;
         logic [STAMP_W-1:0] win;
         r = '0;
         r.channel = ch;
         if (enable_mask[ch]) begin
            gap = now - stamp[ch];
            win = window[ch];
            if (gap >= win) begin
               r.accepted = 1'b1;
               stamp[ch] = now;
               if (lvl && !level[ch]) begin
                  rises[ch] = rises[ch] + 1'b1;
                  r.rose = 1'b1;
               end
               level[ch] = lvl;
            end
            r.level = level[ch];
            r.count = rises[ch];
         end
         expected_q.push_back(r);
      endfunction

      function void check_response(event_result_type got);
         event_result_type want;
         if (expected_q.size() == 0) begin
            $error("response on channel %0d with no request outstanding", got.channel);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.channel !== want.channel) begin
            $error("out_channel: expected %0d, actual %0d", want.channel, got.channel);
            errors++;
         end
         if (got.level !== want.level) begin
            $error("out_level: expected %0d, actual %0d", want.level, got.level);
            errors++;
         end
         if (got.count !== want.count) begin
            $error("edge_count: expected %0d, actual %0d", want.count, got.count);
            errors++;
         end
         if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
            errors++;
         end
         if (got.rose !== want.rose) begin
            $error("rising_counted: expected %0d, actual %0d", want.rose, got.rose);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   dec_req_if req_bus();
   dec_rsp_if rsp_bus();
   dec_csr_if csr_bus();

   debounced_edge_counter_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   edge_count_scoreboard sb = new();

   int req_idle_pct = 12;
   int rsp_idle_pct = 12;
   bit hold_request = 1'b0;
   bit hold_done    = 1'b0;
   int quiet_cycles = 0;

   // stimulus-side view of each channel: last timestamp and level sent, window programmed
   logic [STAMP_W-1:0] sent_ms [CHANNELS] = '{default: '0};
   logic               last_lvl [CHANNELS] = '{default: 1'b0};
   logic [WIN_W-1:0]   win_set [CHANNELS] = '{default: '0};

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.channel, req_bus.pin_level, req_bus.now_ms);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_response({rsp_bus.out_channel, rsp_bus.out_level, rsp_bus.edge_count,
                               rsp_bus.accepted, rsp_bus.rising_counted});
         end
         if (csr_bus.valid && csr_bus.ready) begin
            sb.write_reg(csr_bus.index, csr_bus.data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("debounced_edge_counter_core_tb: errors");
         $finish;
      end
   end

   // Response side: random back-pressure plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_request(input logic [CHAN_W-1:0] ch, input logic lvl,
                               input logic [STAMP_W-1:0] now);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.channel   <= ch;
      req_bus.pin_level <= lvl;
      req_bus.now_ms    <= now;
      do @(posedge clock); while (!req_bus.ready);
      sent_ms[ch]  = now;
      last_lvl[ch] = lvl;
   endtask

   // Drop valid and wait until every response has come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] wdata);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= wdata;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic apply_config(input logic [CHANNELS-1:0] mask,
                               input logic [CHANNELS-1:0][WIN_W-1:0] wins);
      write_reg(CSR_ENABLE_MASK, {12'($urandom), mask});
      for (int c = 0; c < CHANNELS; c++) begin
         write_reg(csr_index_type'(CSR_DEBOUNCE_CH0 + c), wins[c]);
         win_set[c] = wins[c];
      end
      // unmapped index must leave everything alone
      write_reg(csr_index_type'(CSR_DEBOUNCE_CH3 + 1 + $urandom_range(2)), 16'($urandom));
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [WIN_W-1:0] pick_window();
      case ($urandom_range(4))
         0: return '0;
         1: return 16'd1;
         2: return 16'($urandom_range(2, 60));
         3: return 16'($urandom_range(61, 5000));
         default: return '1;
      endcase
   endfunction

   // Mostly timestamps placed around each channel's window, some pure noise.
   task automatic run_phase(input int count);
      logic [CHAN_W-1:0]  ch;
      logic               lvl;
      logic [STAMP_W-1:0] now;
      int                 pick;
      for (int n = 0; n < count; n++) begin
         ch   = CHAN_W'($urandom_range(CHANNELS - 1));
         lvl  = ($urandom_range(9) < 7) ? ~last_lvl[ch] : 1'($urandom);
         pick = $urandom_range(19);
         if (pick < 3) begin
            now = $urandom;
         end else if (pick < 8) begin
            now = sent_ms[ch] + win_set[ch] - 1 + $urandom_range(2);
         end else if (pick < 13) begin
            now = sent_ms[ch] + ((win_set[ch] == 0) ? 0 : $urandom_range(win_set[ch] - 1));
         end else begin
            now = sent_ms[ch] + win_set[ch] + $urandom_range(2000);
         end
         send_request(ch, lvl, now);
      end
   endtask

   initial begin
      logic [CHANNELS-1:0][WIN_W-1:0] wins;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.channel   <= '0;
      req_bus.pin_level <= 1'b0;
      req_bus.now_ms    <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_ENABLE_MASK;
      csr_bus.data      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // all channels disabled out of reset
      send_request(2'd0, 1'b1, '1);
      send_request(2'd3, 1'b0, '0);
      drain();

      wins = {16'd1, 16'd10, 16'hFFFF, 16'd0};
      apply_config(4'hF, wins);
      // widest window: first event after reset falls inside it
      send_request(2'd1, 1'b1, 32'd5);
      send_request(2'd1, 1'b1, 32'h0000_FFFF);
      send_request(2'd1, 1'b0, 32'h0001_FFFD);
      send_request(2'd1, 1'b0, 32'h0001_FFFE);
      // zero window takes everything, repeated high does not count again
      send_request(2'd0, 1'b1, 32'd0);
      send_request(2'd0, 1'b1, 32'd0);
      send_request(2'd0, 1'b0, 32'd0);
      send_request(2'd0, 1'b1, 32'hFFFF_FFFF);
      // window edges and a timestamp wrap
      send_request(2'd2, 1'b1, 32'd9);
      send_request(2'd2, 1'b1, 32'd10);
      send_request(2'd2, 1'b0, 32'd19);
      send_request(2'd2, 1'b0, 32'd20);
      send_request(2'd2, 1'b1, 32'hFFFF_FFF0);
      send_request(2'd2, 1'b0, 32'h0000_0005);
      send_request(2'd2, 1'b1, 32'h0000_000E);
      send_request(2'd3, 1'b1, 32'd0);
      send_request(2'd3, 1'b1, 32'd1);
      send_request(2'd3, 1'b1, 32'd1);
      drain();

      for (int p = 0; p < 6; p++) begin
         for (int c = 0; c < CHANNELS; c++) begin
            wins[c] = (p == 1) ? '1 : pick_window();
         end
         case (p) inside
            0, 1: apply_config(4'hF, wins);
            2: apply_config(4'($urandom_range(1, 14)), wins);
            3: apply_config(4'h0, wins);
            default: apply_config(4'($urandom), wins);
         endcase
         req_idle_pct = (p == 0) ? 0 : 12;
         rsp_idle_pct = (p == 0) ? 0 : 12;
         if (p == 2) begin
            hold_request = 1'b1;
         end
         run_phase(PHASE_ITEMS);
         drain();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("debounced_edge_counter_core_tb: clean");
      end else begin
         $display("debounced_edge_counter_core_tb: errors");
      end
      $finish;
   end

endmodule
